[rtl/joystick_half_step_steering_unit_macros.svh]
// assertion macros for the steering unit checker
// expects clk_i and rst_ni in the scope of each use
`ifndef JOYSTICK_HALF_STEP_STEERING_UNIT_MACROS_SVH
`define JOYSTICK_HALF_STEP_STEERING_UNIT_MACROS_SVH

// same-cycle implication
`define JHSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JHSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jhss_pkg.sv]
// types, register indexes, codes and the coil table of the steering unit
// no dependencies
`timescale 1ns / 1ps

package jhss_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned STEP_W     = 12;
  localparam int unsigned COIL_W     = 4;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [COIL_W-1:0]     coil_t;
  typedef logic [PHASE_W-1:0]    phase_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [DIR_W-1:0]      dir_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_HIGH_THR = 2'd0;
  localparam cfg_idx_t CFG_LOW_THR  = 2'd1;
  localparam cfg_idx_t CFG_STEPS    = 2'd2;

  localparam sample_t HIGH_THR_RST = 10'd600;
  localparam sample_t LOW_THR_RST  = 10'd400;
  localparam step_t   STEPS_RST    = 12'd227;

  localparam mode_t MODE_IDLE   = 3'd0;
  localparam mode_t MODE_RIGHT  = 3'd1;
  localparam mode_t MODE_LEFT   = 3'd2;
  localparam mode_t MODE_WAIT   = 3'd3;
  localparam mode_t MODE_RETURN = 3'd4;

  localparam dir_t DIR_BWD  = 2'd0;
  localparam dir_t DIR_FWD  = 2'd1;
  localparam dir_t DIR_NONE = 2'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  function automatic coil_t coil_of(phase_t p);
    coil_t c;
    case (p)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

endpackage

[rtl/jhss_if.sv]
// valid/ready channel interfaces: input items, results, register writes
// depends on jhss_pkg
`timescale 1ns / 1ps

interface jhss_item_if;
  logic              valid;
  logic              ready;
  logic              op;
  jhss_pkg::sample_t stick_sample;

  modport source (output valid, op, stick_sample, input ready);
  modport sink   (input valid, op, stick_sample, output ready);
endinterface

interface jhss_result_if;
  logic            valid;
  logic            ready;
  jhss_pkg::coil_t coil_pattern;
  logic            moving;

  modport source (output valid, coil_pattern, moving, input ready);
  modport sink   (input valid, coil_pattern, moving, output ready);
endinterface

interface jhss_cfg_if;
  logic                valid;
  logic                ready;
  jhss_pkg::cfg_idx_t  index;
  jhss_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/joystick_half_step_steering_unit.sv]
// steering unit top level: stick state machine and half-step coil sequencer
// depends on jhss_pkg and the interfaces in jhss_if.sv
`timescale 1ns / 1ps

// Each accepted transaction on item_i (op 1: stick sample, op 0: stepper tick)
// yields exactly one transaction on result_o with the coil pattern of the
// current phase and the moving flag, in order. A new item is taken every
// cycle while item_i.ready is high. The item is registered in the input
// register, and the logic after that register updates the state. The result
// then sits in the result register, which drives result_o. item_i.ready drops
// only while the result register is full and not taken and the input
// register also holds an item. Register writes on cfg_i are always accepted
// and take effect at once.
module joystick_half_step_steering_unit (
  input logic           clk_i,
  input logic           rst_ni,
  jhss_item_if.sink     item_i,
  jhss_result_if.source result_o,
  jhss_cfg_if.sink      cfg_i
);
  import jhss_pkg::*;

  sample_t high_thr_q, low_thr_q;
  step_t   steps_q;

  phase_t  phase_q, phase_d;
  dir_t    dir_q, dir_d;
  step_t   count_q, count_d;
  step_t   target_q, target_d;
  mode_t   mode_q, mode_d;

  logic    in_vld_q;
  logic    in_op_q;
  sample_t in_sample_q;

  logic    out_vld_q;
  coil_t   out_coil_q;
  logic    out_moving_q;

  logic    advance;
  logic    fire;
  logic    accept;

  assign advance = !out_vld_q || result_o.ready;
  assign fire    = in_vld_q && advance;
  assign accept  = item_i.valid && item_i.ready;

  assign item_i.ready          = !in_vld_q || advance;
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_vld_q;
  assign result_o.coil_pattern = out_coil_q;
  assign result_o.moving       = out_moving_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HIGH_THR_RST;
      low_thr_q  <= LOW_THR_RST;
      steps_q    <= STEPS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HIGH_THR: high_thr_q <= cfg_i.data[SAMPLE_W-1:0];
        CFG_LOW_THR:  low_thr_q  <= cfg_i.data[SAMPLE_W-1:0];
        CFG_STEPS:    steps_q    <= cfg_i.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // next state for the item in the input register
  always_comb begin
    phase_d  = phase_q;
    dir_d    = dir_q;
    count_d  = count_q;
    target_d = target_q;
    mode_d   = mode_q;
    if (in_op_q == OP_SAMPLE) begin
      case (mode_q)
        MODE_RIGHT, MODE_LEFT: mode_d = MODE_WAIT;
        MODE_WAIT: begin
          if (in_sample_q > low_thr_q && in_sample_q < high_thr_q) begin
            mode_d = MODE_RETURN;
          end else begin
            mode_d = MODE_WAIT;
          end
        end
        MODE_RETURN: mode_d = MODE_IDLE;
        default: begin
          if (in_sample_q > high_thr_q) begin
            mode_d = MODE_RIGHT;
          end else if (in_sample_q < low_thr_q) begin
            mode_d = MODE_LEFT;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
      endcase
      if (mode_d == MODE_RIGHT) begin
        dir_d    = DIR_FWD;
        target_d = steps_q;
      end else if (mode_d == MODE_LEFT) begin
        dir_d    = DIR_BWD;
        target_d = steps_q;
      end else if (mode_d == MODE_RETURN) begin
        if (dir_q == DIR_FWD) begin
          dir_d    = DIR_BWD;
          target_d = steps_q;
        end else if (dir_q == DIR_BWD) begin
          dir_d    = DIR_FWD;
          target_d = steps_q;
        end
      end
    end else if (dir_q inside {DIR_FWD, DIR_BWD}) begin
      if (count_q != target_q) begin
        count_d = count_q + step_t'(1);
        if (dir_q == DIR_FWD) begin
          phase_d = phase_q + phase_t'(1);
        end else begin
          phase_d = phase_q - phase_t'(1);
        end
      end else begin
        count_d  = '0;
        target_d = '0;
      end
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      dir_q     <= DIR_NONE;
      count_q   <= '0;
      target_q  <= '0;
      mode_q    <= MODE_IDLE;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        phase_q  <= phase_d;
        dir_q    <= dir_d;
        count_q  <= count_d;
        target_q <= target_d;
        mode_q   <= mode_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q     <= item_i.op;
      in_sample_q <= item_i.stick_sample;
    end
    if (fire) begin
      out_coil_q   <= coil_of(phase_d);
      out_moving_q <= (count_d != target_d);
    end
  end

endmodule

[rtl/jhss_checker.sv]
// port-level checker for the steering unit, bound to the top level
// depends on jhss_pkg and joystick_half_step_steering_unit_macros.svh
`timescale 1ns / 1ps

`include "joystick_half_step_steering_unit_macros.svh"

module jhss_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input jhss_pkg::coil_t out_coil_i
);
  import jhss_pkg::*;

  `JHSS_ASSERT_IMPLY(a_coil_legal, out_valid_i, (out_coil_i == 4'h1 || out_coil_i == 4'h3 || out_coil_i == 4'h2 || out_coil_i == 4'h6 || out_coil_i == 4'h4 || out_coil_i == 4'hC || out_coil_i == 4'h8 || out_coil_i == 4'h9), "illegal coil pattern")
  `JHSS_ASSERT_IMPLY(a_ready_only_on_stall, !in_ready_i, (out_valid_i && !out_ready_i), "input stalled without output back-pressure")
  `JHSS_ASSERT_IMPLY(a_result_has_item, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without accepted transaction")
  `JHSS_ASSERT_NEXT(a_result_held, (out_valid_i && !out_ready_i), (out_valid_i && $stable(out_coil_i)), "stalled result dropped or changed")

endmodule

bind joystick_half_step_steering_unit jhss_checker u_jhss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_coil_i  (result_o.coil_pattern)
);

[tb/sv/joystick_half_step_steering_unit_tb.sv]
// self-checking testbench for the joystick half-step steering unit
// drives stick samples, stepper ticks and register writes, predicts coil pattern and moving flag
// depends on jhss_pkg, the channel interfaces in jhss_if.sv and the steering unit top level
`timescale 1ns / 1ps

module joystick_half_step_steering_unit_tb;
  import jhss_pkg::*;

  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned HOLD_LEN  = 100;
  localparam int unsigned PHASE_N   = 6;
  localparam int unsigned PHASE_LEN = 135;
  localparam cfg_idx_t    CFG_SPARE = 2'd3;

  typedef struct packed {
    logic    op;
    sample_t smp;
  } stick_item_t;

  typedef struct packed {
    coil_t coil;
    logic  moving;
  } coil_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jhss_item_if   item_if();
  jhss_result_if res_if();
  jhss_cfg_if    cfg_if();

  joystick_half_step_steering_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  coil_t coil_seq [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  // predicted register and steering state
  sample_t thr_hi;
  sample_t thr_lo;
  step_t   steps_cfg;
  phase_t  mdl_phase;
  dir_t    mdl_dir;
  step_t   mdl_cnt;
  step_t   mdl_tgt;
  mode_t   mdl_mode;

  stick_item_t stick_q [$];
  coil_out_t   coil_due_q [$];

  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned err_cnt;
  int unsigned cyc;
  int unsigned src_gap_max;
  int unsigned snk_gap_max;
  int unsigned src_wait;
  int unsigned snk_wait;
  int unsigned hold_cnt;
  logic        hold_armed;
  logic        long_hold;

  assign long_hold = hold_armed && (hold_cnt != HOLD_LEN);

  function automatic void steer_predict(logic op, sample_t smp);
    mode_t     nm;
    coil_out_t r;
    if (op == OP_SAMPLE) begin
      case (mdl_mode)
        MODE_RIGHT, MODE_LEFT: nm = MODE_WAIT;
        MODE_WAIT: nm = (smp > thr_lo && smp < thr_hi) ? MODE_RETURN : MODE_WAIT;
        MODE_RETURN: nm = MODE_IDLE;
        default: nm = (smp > thr_hi) ? MODE_RIGHT : ((smp < thr_lo) ? MODE_LEFT : MODE_IDLE);
      endcase
      mdl_mode = nm;
      if (nm == MODE_RIGHT) begin
        mdl_dir = DIR_FWD;
        mdl_tgt = steps_cfg;
      end else if (nm == MODE_LEFT) begin
        mdl_dir = DIR_BWD;
        mdl_tgt = steps_cfg;
      end else if (nm == MODE_RETURN && (mdl_dir == DIR_FWD || mdl_dir == DIR_BWD)) begin
        mdl_dir = (mdl_dir == DIR_FWD) ? DIR_BWD : DIR_FWD;
        mdl_tgt = steps_cfg;
      end
    end else if (mdl_dir == DIR_FWD || mdl_dir == DIR_BWD) begin
      if (mdl_cnt != mdl_tgt) begin
        mdl_cnt = mdl_cnt + 1'b1;
        mdl_phase = (mdl_dir == DIR_FWD) ? mdl_phase + 1'b1 : mdl_phase - 1'b1;
      end else begin
        mdl_cnt = '0;
        mdl_tgt = '0;
      end
    end
    r.coil   = coil_seq[mdl_phase];
    r.moving = (mdl_cnt != mdl_tgt);
    coil_due_q.push_back(r);
  endfunction

  task automatic report_err(string msg);
    if (err_cnt < 10) $display("%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin : item_drv
    stick_item_t nxt;
    if (!rst_ni) begin
      item_if.valid        <= 1'b0;
      item_if.op           <= OP_TICK;
      item_if.stick_sample <= '0;
      src_wait             <= 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        steer_predict(item_if.op, item_if.stick_sample);
        items_taken++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (src_wait != 0) begin
          src_wait      <= src_wait - 1;
          item_if.valid <= 1'b0;
        end else if (stick_q.size() != 0) begin
          nxt = stick_q.pop_front();
          item_if.valid        <= 1'b1;
          item_if.op           <= nxt.op;
          item_if.stick_sample <= nxt.smp;
          src_wait             <= $urandom_range(0, src_gap_max);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : res_mon
    coil_out_t   exp_r;
    int unsigned w;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_wait     <= 0;
    end else begin
      w = snk_wait;
      if (res_if.valid && res_if.ready) begin
        if (coil_due_q.size() == 0) begin
          report_err($sformatf("unexpected result coil %h moving %b",
                               res_if.coil_pattern, res_if.moving));
        end else begin
          exp_r = coil_due_q.pop_front();
          if (res_if.coil_pattern !== exp_r.coil)
            report_err($sformatf("coil_pattern exp %h got %h", exp_r.coil,
                                 res_if.coil_pattern));
          if (res_if.moving !== exp_r.moving)
            report_err($sformatf("moving exp %b got %b", exp_r.moving, res_if.moving));
        end
        w = $urandom_range(0, snk_gap_max);
      end else if (w != 0 && !long_hold) begin
        w = w - 1;
      end
      snk_wait     <= w;
      res_if.ready <= (w == 0) && !long_hold;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_cnt <= 0;
    else if (long_hold) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_item(logic op, sample_t smp);
    stick_item_t it;
    it.op  = op;
    it.smp = smp;
    stick_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_item(OP_TICK, sample_t'($urandom_range(0, 1023)));
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (items_taken != items_queued || coil_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_HIGH_THR: thr_hi = val[SAMPLE_W-1:0];
      CFG_LOW_THR:  thr_lo = val[SAMPLE_W-1:0];
      CFG_STEPS:    steps_cfg = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // upper data bits above the threshold width are random junk
  task automatic set_regs(int unsigned hi, int unsigned lo, int unsigned st);
    write_reg(CFG_HIGH_THR, cfg_data_t'(($urandom_range(0, 3) << SAMPLE_W) | hi));
    write_reg(CFG_LOW_THR, cfg_data_t'(($urandom_range(0, 3) << SAMPLE_W) | lo));
    write_reg(CFG_STEPS, cfg_data_t'(st));
  endtask

  // bring the stick back to idle and clear counter and target
  task automatic settle();
    write_reg(CFG_HIGH_THR, cfg_data_t'(1023));
    write_reg(CFG_LOW_THR, '0);
    repeat (3) push_item(OP_SAMPLE, sample_t'(512));
    drain();
    if (mdl_dir == DIR_FWD || mdl_dir == DIR_BWD) begin
      if (mdl_cnt != mdl_tgt) begin
        // turn and return with the current count as target
        write_reg(CFG_STEPS, cfg_data_t'(mdl_cnt));
        write_reg(CFG_HIGH_THR, cfg_data_t'(600));
        push_item(OP_SAMPLE, sample_t'(1023));
        repeat (3) push_item(OP_SAMPLE, sample_t'(512));
        drain();
      end
      push_ticks(1);
      drain();
    end
  endtask

  function automatic sample_t above_hi();
    return (thr_hi < 10'd1023) ? sample_t'($urandom_range(thr_hi + 1, 1023)) : '1;
  endfunction

  function automatic sample_t below_lo();
    return (thr_lo > 0) ? sample_t'($urandom_range(0, thr_lo - 1)) : '0;
  endfunction

  function automatic sample_t centre();
    return (thr_hi > thr_lo + 1) ? sample_t'($urandom_range(thr_lo + 1, thr_hi - 1))
                                 : sample_t'($urandom_range(0, 1023));
  endfunction

  task automatic gen_turn();
    int unsigned cap;
    cap = (steps_cfg + 2 < 24) ? steps_cfg + 2 : 24;
    push_item(OP_SAMPLE, $urandom_range(0, 1) ? above_hi() : below_lo());
    push_item(OP_SAMPLE, sample_t'($urandom_range(0, 1023)));
    push_ticks($urandom_range(0, cap));
    repeat ($urandom_range(0, 2))
      push_item(OP_SAMPLE, $urandom_range(0, 1) ? above_hi() : below_lo());
    push_item(OP_SAMPLE, centre());
    push_item(OP_SAMPLE, sample_t'($urandom_range(0, 1023)));
    push_ticks($urandom_range(0, cap));
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4))
      push_item(logic'($urandom_range(0, 1)), sample_t'($urandom_range(0, 1023)));
  endtask

  initial begin
    int unsigned start;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_HIGH_THR;
    cfg_if.data  <= '0;
    hold_armed   <= 1'b0;
    src_gap_max  = 14;
    snk_gap_max  = 14;
    thr_hi       = HIGH_THR_RST;
    thr_lo       = LOW_THR_RST;
    steps_cfg    = STEPS_RST;
    mdl_phase    = '0;
    mdl_dir      = DIR_NONE;
    mdl_cnt      = '0;
    mdl_tgt      = '0;
    mdl_mode     = MODE_IDLE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: tick with no direction, turn right, return, turn left
    push_item(OP_TICK, '0);
    push_item(OP_SAMPLE, sample_t'(500));
    push_item(OP_SAMPLE, sample_t'(1023));
    push_item(OP_SAMPLE, sample_t'(0));
    push_ticks(3);
    push_item(OP_SAMPLE, sample_t'(0));
    push_item(OP_SAMPLE, sample_t'(600));
    push_item(OP_SAMPLE, sample_t'(400));
    push_item(OP_SAMPLE, sample_t'(401));
    push_item(OP_SAMPLE, sample_t'(0));
    push_ticks(2);
    push_item(OP_SAMPLE, sample_t'(399));
    push_item(OP_SAMPLE, sample_t'(601));
    push_item(OP_SAMPLE, sample_t'(599));
    push_item(OP_SAMPLE, sample_t'(1023));
    push_item(OP_SAMPLE, sample_t'(600));
    push_item(OP_SAMPLE, sample_t'(400));
    drain();
    settle();

    // crossed thresholds, spare register index
    set_regs(100, 900, 2);
    write_reg(CFG_SPARE, cfg_data_t'($urandom_range(0, 4095)));
    push_item(OP_SAMPLE, sample_t'(50));
    push_item(OP_SAMPLE, sample_t'(500));
    push_item(OP_SAMPLE, sample_t'(500));
    push_ticks(4);
    drain();
    settle();

    // reload below the counter: counter keeps counting past the target
    set_regs(600, 400, 12);
    push_item(OP_SAMPLE, sample_t'(0));
    push_item(OP_SAMPLE, sample_t'(0));
    push_ticks(8);
    drain();
    write_reg(CFG_STEPS, cfg_data_t'(3));
    push_item(OP_SAMPLE, sample_t'(500));
    push_ticks(6);
    drain();
    settle();

    for (int p = 0; p < PHASE_N; p++) begin
      case (p)
        0: begin set_regs(1023, 0, 0);    src_gap_max = 14; snk_gap_max = 14; end
        1: begin set_regs(0, 1023, 3);    src_gap_max = 0;  snk_gap_max = 0;  end
        2: begin set_regs(700, 300, 6);   src_gap_max = 14; snk_gap_max = 0;  end
        3: begin set_regs(512, 511, 4095); src_gap_max = 0; snk_gap_max = 14; end
        4: begin
          set_regs(600, 400, 10);
          src_gap_max = 0;
          snk_gap_max = 3;
          hold_armed <= 1'b1;
        end
        default: begin
          set_regs($urandom_range(512, 1023), $urandom_range(0, 511), $urandom_range(1, 20));
          src_gap_max = $urandom_range(0, 14);
          snk_gap_max = $urandom_range(0, 14);
        end
      endcase
      start = items_queued;
      while (items_queued - start < PHASE_LEN) begin
        if ($urandom_range(0, 3) != 0) gen_turn();
        else gen_noise();
      end
      drain();
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
